@@ rtl/pid_motor_speed_controller_assert.svh @@
// assertion macros shared by the speed controller rtl
`ifndef PID_MOTOR_SPEED_CONTROLLER_ASSERT_SVH
`define PID_MOTOR_SPEED_CONTROLLER_ASSERT_SVH

// same-cycle implication, clocked on clk, held off during reset
`define PMSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, held off during reset
`define PMSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pmsc_pkg.sv @@
// shared types and constants of the pid motor speed controller
package pmsc_pkg;

    // system constants
    localparam int CLOCK_HZ       = 16000000;
    localparam int PULSES_PER_REV = 7;

    // 60 * clock rate, the numerator of the speed division
    localparam longint unsigned SPEED_NUM = 64'd60 * 64'(CLOCK_HZ);

    // field widths
    localparam int PERIOD_W   = 32;
    localparam int RPM_W      = 16;
    localparam int SETPOINT_W = 13;
    localparam int GAIN_W     = 16;
    localparam int ERR_W      = 18;
    localparam int DER_W      = ERR_W + 1;
    localparam int INTEG_W    = 40;
    localparam int DUTY_W     = 8;
    localparam int DISP_W     = 8;

    // shared multiplier sizes
    localparam int MCAND_W = INTEG_W + 1;
    localparam int PROD_W  = MCAND_W + GAIN_W;
    localparam int SUM_W   = PROD_W + 1;

    // integral decay of about 0.975 in q0.16
    localparam logic [GAIN_W-1:0] DECAY_Q16 = 16'd63898;

    // display scaling: floor(rpm * 78 / 1000), saturated above the limit
    localparam logic [RPM_W-1:0] DISP_LIMIT_RPM = 16'd3269;
    localparam int               DISP_X_W       = 18;
    localparam logic [DISP_X_W-1:0] DISP_SCALE  = 18'd78;
    localparam int               DISP_RECIP_W   = 19;
    localparam logic [DISP_RECIP_W-1:0] DISP_RECIP = 19'd268436;
    localparam int               DISP_SHIFT     = 28;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETPOINT   = 2'd0,
        REG_GAIN_PROP  = 2'd1,
        REG_GAIN_INTEG = 2'd2,
        REG_GAIN_DERIV = 2'd3
    } cfg_reg_t;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_sts_t;

endpackage

@@ rtl/pmsc_in_if.sv @@
// period measurement channel
interface pmsc_in_if import pmsc_pkg::*;;
    logic                valid;
    logic                ready;
    logic [PERIOD_W-1:0] period_ticks;

    modport source (output valid, output period_ticks, input ready);
    modport sink   (input valid, input period_ticks, output ready);
endinterface

@@ rtl/pmsc_out_if.sv @@
// drive and display result channel
interface pmsc_out_if import pmsc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [DUTY_W-1:0] drive_duty;
    logic [DISP_W-1:0] speed_display;

    modport source (output valid, output drive_duty, output speed_display, input ready);
    modport sink   (input valid, input drive_duty, input speed_display, output ready);
endinterface

@@ rtl/pmsc_div.sv @@
// bit-serial restoring divider turning a pulse period into rpm
module pmsc_div import pmsc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [PERIOD_W-1:0] period,
    output logic [RPM_W-1:0]    rpm,
    output unit_sts_t           sts
);

    localparam int DEN_W = PERIOD_W + $clog2(PULSES_PER_REV + 1);
    localparam int CNT_W = $clog2(RPM_W);

    typedef enum logic [1:0] {
        D_IDLE,
        D_CHECK,
        D_RUN,
        D_DONE
    } div_state_t;

    localparam logic [DEN_W-1:0] NUM_HI = DEN_W'(SPEED_NUM >> RPM_W);
    localparam logic [RPM_W-1:0] NUM_LO = RPM_W'(SPEED_NUM);

    div_state_t       state_reg, state_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [RPM_W-1:0] lo_reg, lo_next;
    logic [RPM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           fits;

    always_comb
    begin
        trial = {rem_reg, lo_reg[RPM_W-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};

        state_next = state_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;

        case (state_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    den_next   = DEN_W'(period) * DEN_W'(PULSES_PER_REV);
                    state_next = D_CHECK;
                end
            end
            D_CHECK:
            begin
                // quotient would not fit in 16 bits (zero period included)
                if (den_reg <= NUM_HI)
                begin
                    quo_next   = '1;
                    state_next = D_DONE;
                end
                else
                begin
                    rem_next   = NUM_HI;
                    lo_next    = NUM_LO;
                    cnt_next   = CNT_W'(RPM_W - 1);
                    state_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                quo_next = {quo_reg[RPM_W-2:0], fits};
                lo_next  = {lo_reg[RPM_W-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = D_DONE;
                end
            end
            D_DONE:
            begin
                state_next = D_IDLE;
            end
            default:
            begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            den_reg   <= '0;
            rem_reg   <= '0;
            lo_reg    <= '0;
            quo_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            den_reg   <= den_next;
            rem_reg   <= rem_next;
            lo_reg    <= lo_next;
            quo_reg   <= quo_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign rpm      = quo_reg;
    assign sts.busy = state_reg != D_IDLE;
    assign sts.done = state_reg == D_DONE;

endmodule

@@ rtl/pmsc_mul.sv @@
// bit-serial shift-add multiplier, signed multiplicand by unsigned multiplier
module pmsc_mul import pmsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [MCAND_W-1:0] mcand,
    input  logic [GAIN_W-1:0]         mplier,
    output logic signed [PROD_W-1:0]  prod,
    output unit_sts_t                 sts
);

    localparam int CNT_W = $clog2(GAIN_W);

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_DONE
    } mul_state_t;

    mul_state_t         state_reg, state_next;
    logic [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [MCAND_W-1:0] acc_reg, acc_next;
    logic [GAIN_W-1:0]  mreg_reg, mreg_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;

    logic [MCAND_W:0] sum;

    always_comb
    begin
        // partial sum, then an arithmetic shift right by one
        sum = {acc_reg[MCAND_W-1], acc_reg}
            + (mreg_reg[0] ? {mcand_reg[MCAND_W-1], mcand_reg} : '0);

        state_next = state_reg;
        mcand_next = mcand_reg;
        acc_next   = acc_reg;
        mreg_next  = mreg_reg;
        cnt_next   = cnt_reg;

        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    mcand_next = mcand;
                    mreg_next  = mplier;
                    acc_next   = '0;
                    cnt_next   = CNT_W'(GAIN_W - 1);
                    state_next = M_RUN;
                end
            end
            M_RUN:
            begin
                acc_next  = sum[MCAND_W:1];
                mreg_next = {sum[0], mreg_reg[GAIN_W-1:1]};
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = M_DONE;
                end
            end
            M_DONE:
            begin
                state_next = M_IDLE;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            mcand_reg <= '0;
            acc_reg   <= '0;
            mreg_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            mcand_reg <= mcand_next;
            acc_reg   <= acc_next;
            mreg_reg  <= mreg_next;
            cnt_reg   <= cnt_next;
        end
    end

    assign prod     = {acc_reg, mreg_reg};
    assign sts.busy = state_reg != M_IDLE;
    assign sts.done = state_reg == M_DONE;

endmodule

@@ rtl/pid_motor_speed_controller.sv @@
// top level of the pid motor speed controller
//
// Takes one tachometer period per transaction on meas and returns one
// transaction on result carrying the pwm drive duty and the speed display
// value. Speed is 60*CLOCK_HZ/(PULSES_PER_REV*period) rpm, saturated at 65535
// (a zero period saturates too). The pid update integrates only positive
// errors and otherwise decays the integral by 63898/65536; gains are unsigned
// q8.8, the sum is truncated and clamped to 0..255. One item is worked at a
// time: after acceptance the bit-serial divider runs its 16 quotient steps,
// skipped when the speed saturates, then the single shift-add multiplier
// (16 steps per product) runs three products per item, four when the
// integral decays, and the result is loaded; the next period is taken once
// the block is back in idle after the load. A finished result sits in the
// output register, so the next period is taken while it waits. Configuration
// writes on cfg_wr_en/cfg_index/cfg_data are registered and must only be
// issued while the block is idle.
module pid_motor_speed_controller import pmsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    pmsc_in_if.sink               meas,
    pmsc_out_if.source            result,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "pid_motor_speed_controller_assert.svh"

    localparam int DISP_PROD_W = DISP_X_W + DISP_RECIP_W;

    // top-level sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_INT,
        ST_DECAY,
        ST_PROP,
        ST_INTEG,
        ST_DERIV,
        ST_OUT
    } top_state_t;

    top_state_t state_reg, state_next;

    // configuration registers
    logic [SETPOINT_W-1:0] setpoint_reg, setpoint_next;
    logic [GAIN_W-1:0]     gain_prop_reg, gain_prop_next;
    logic [GAIN_W-1:0]     gain_integ_reg, gain_integ_next;
    logic [GAIN_W-1:0]     gain_deriv_reg, gain_deriv_next;

    // controller state kept from item to item
    logic [INTEG_W-1:0] integ_reg, integ_next;
    logic [ERR_W-1:0]   prev_err_reg, prev_err_next;

    // per-item working registers
    logic [ERR_W-1:0]    err_reg, err_next;
    logic [DER_W-1:0]    der_reg, der_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [DISP_X_W-1:0] disp_x_reg, disp_x_next;
    logic                disp_sat_reg, disp_sat_next;
    logic [DISP_W-1:0]   disp_reg, disp_next;

    // multiplier launch
    logic               mul_start_reg, mul_start_next;
    logic [MCAND_W-1:0] mcand_reg, mcand_next;
    logic [GAIN_W-1:0]  mplier_reg, mplier_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [DUTY_W-1:0] out_duty_reg, out_duty_next;
    logic [DISP_W-1:0] out_disp_reg, out_disp_next;

    // serial units
    logic [RPM_W-1:0]  div_rpm;
    unit_sts_t         div_sts;
    logic [PROD_W-1:0] mul_prod;
    unit_sts_t         mul_sts;

    // combinational helpers
    logic                   meas_fire;
    logic                   out_fire;
    logic                   out_free;
    logic                   out_load;
    logic                   err_pos;
    logic [INTEG_W:0]       integ_inc;
    logic [SUM_W-1:0]       prod_ext;
    logic [DISP_PROD_W-1:0] disp_prod;
    logic [DUTY_W-1:0]      duty;

    pmsc_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (meas_fire),
        .period (meas.period_ticks),
        .rpm    (div_rpm),
        .sts    (div_sts)
    );

    pmsc_mul u_mul
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mul_start_reg),
        .mcand  (mcand_reg),
        .mplier (mplier_reg),
        .prod   (mul_prod),
        .sts    (mul_sts)
    );

    assign meas.ready = state_reg == ST_IDLE;
    assign meas_fire  = meas.valid && meas.ready;
    assign out_fire   = result.valid && result.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign out_load   = (state_reg == ST_OUT) && out_free;

    always_comb
    begin
        err_pos   = !err_reg[ERR_W-1] && (err_reg != '0);
        integ_inc = {1'b0, integ_reg} + (INTEG_W + 1)'(err_reg[ERR_W-2:0]);
        prod_ext  = {mul_prod[PROD_W-1], mul_prod};
        disp_prod = DISP_PROD_W'(disp_x_reg) * DISP_PROD_W'(DISP_RECIP);

        // negative sum gives zero, anything from 256 up clamps
        if (sum_reg[SUM_W-1])
        begin
            duty = '0;
        end
        else if (sum_reg[SUM_W-2:DUTY_W+8] != '0)
        begin
            duty = '1;
        end
        else
        begin
            duty = sum_reg[DUTY_W+7:8];
        end

        state_next      = state_reg;
        setpoint_next   = setpoint_reg;
        gain_prop_next  = gain_prop_reg;
        gain_integ_next = gain_integ_reg;
        gain_deriv_next = gain_deriv_reg;
        integ_next      = integ_reg;
        prev_err_next   = prev_err_reg;
        err_next        = err_reg;
        der_next        = der_reg;
        sum_next        = sum_reg;
        disp_x_next     = disp_x_reg;
        disp_sat_next   = disp_sat_reg;
        disp_next       = disp_reg;
        mul_start_next  = 1'b0;
        mcand_next      = mcand_reg;
        mplier_next     = mplier_reg;
        out_valid_next  = out_valid_reg;
        out_duty_next   = out_duty_reg;
        out_disp_next   = out_disp_reg;

        // register writes, to be issued only while idle; the block does not check this
        if (cfg_wr_en)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_SETPOINT:   setpoint_next   = cfg_data[SETPOINT_W-1:0];
                REG_GAIN_PROP:  gain_prop_next  = cfg_data[GAIN_W-1:0];
                REG_GAIN_INTEG: gain_integ_next = cfg_data[GAIN_W-1:0];
                REG_GAIN_DERIV: gain_deriv_next = cfg_data[GAIN_W-1:0];
                default:        ;
            endcase
        end

        if (out_fire)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                // divider picks the period up on the same edge
                if (meas_fire)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    err_next      = ERR_W'(setpoint_reg) - ERR_W'(div_rpm);
                    disp_sat_next = div_rpm > DISP_LIMIT_RPM;
                    disp_x_next   = DISP_X_W'(div_rpm) * DISP_SCALE;
                    state_next    = ST_INT;
                end
            end
            ST_INT:
            begin
                der_next      = {err_reg[ERR_W-1], err_reg}
                              - {prev_err_reg[ERR_W-1], prev_err_reg};
                prev_err_next = err_reg;
                // 78/1000 by reciprocal, exact for every value below the limit
                disp_next     = disp_sat_reg ? '1
                              : disp_prod[DISP_SHIFT+DISP_W-1:DISP_SHIFT];
                if (err_pos)
                begin
                    // conditional integration, saturating at all ones
                    integ_next     = integ_inc[INTEG_W] ? '1 : integ_inc[INTEG_W-1:0];
                    mcand_next     = {{(MCAND_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                    mplier_next    = gain_prop_reg;
                    mul_start_next = 1'b1;
                    state_next     = ST_PROP;
                end
                else
                begin
                    mcand_next     = {1'b0, integ_reg};
                    mplier_next    = DECAY_Q16;
                    mul_start_next = 1'b1;
                    state_next     = ST_DECAY;
                end
            end
            ST_DECAY:
            begin
                if (mul_sts.done)
                begin
                    // high half of the product is the q0.16 floor
                    integ_next     = mul_prod[GAIN_W+INTEG_W-1:GAIN_W];
                    mcand_next     = {{(MCAND_W-ERR_W){err_reg[ERR_W-1]}}, err_reg};
                    mplier_next    = gain_prop_reg;
                    mul_start_next = 1'b1;
                    state_next     = ST_PROP;
                end
            end
            ST_PROP:
            begin
                if (mul_sts.done)
                begin
                    sum_next       = prod_ext;
                    mcand_next     = {1'b0, integ_reg};
                    mplier_next    = gain_integ_reg;
                    mul_start_next = 1'b1;
                    state_next     = ST_INTEG;
                end
            end
            ST_INTEG:
            begin
                if (mul_sts.done)
                begin
                    sum_next       = sum_reg + prod_ext;
                    mcand_next     = {{(MCAND_W-DER_W){der_reg[DER_W-1]}}, der_reg};
                    mplier_next    = gain_deriv_reg;
                    mul_start_next = 1'b1;
                    state_next     = ST_DERIV;
                end
            end
            ST_DERIV:
            begin
                if (mul_sts.done)
                begin
                    sum_next   = sum_reg + prod_ext;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait here only while the previous result is still unread
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_duty_next  = duty;
                    out_disp_next  = disp_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            setpoint_reg   <= 13'd1000;
            gain_prop_reg  <= 16'd410;
            gain_integ_reg <= 16'd77;
            gain_deriv_reg <= 16'd51;
            integ_reg      <= '0;
            prev_err_reg   <= '0;
            err_reg        <= '0;
            der_reg        <= '0;
            sum_reg        <= '0;
            disp_x_reg     <= '0;
            disp_sat_reg   <= 1'b0;
            disp_reg       <= '0;
            mul_start_reg  <= 1'b0;
            mcand_reg      <= '0;
            mplier_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_duty_reg   <= '0;
            out_disp_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            setpoint_reg   <= setpoint_next;
            gain_prop_reg  <= gain_prop_next;
            gain_integ_reg <= gain_integ_next;
            gain_deriv_reg <= gain_deriv_next;
            integ_reg      <= integ_next;
            prev_err_reg   <= prev_err_next;
            err_reg        <= err_next;
            der_reg        <= der_next;
            sum_reg        <= sum_next;
            disp_x_reg     <= disp_x_next;
            disp_sat_reg   <= disp_sat_next;
            disp_reg       <= disp_next;
            mul_start_reg  <= mul_start_next;
            mcand_reg      <= mcand_next;
            mplier_reg     <= mplier_next;
            out_valid_reg  <= out_valid_next;
            out_duty_reg   <= out_duty_next;
            out_disp_reg   <= out_disp_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.drive_duty    = out_duty_reg;
    assign result.speed_display = out_disp_reg;

    // divider finishes only while the sequencer waits for it
    `PMSC_ASSERT_NOW(a_div_done_in_div, div_sts.done, state_reg == ST_DIV,
        "divider finished outside the divide phase")

    // multiplier finishes only in one of the product phases
    `PMSC_ASSERT_NOW(a_mul_done_in_mul, mul_sts.done,
        (state_reg == ST_DECAY) || (state_reg == ST_PROP) ||
        (state_reg == ST_INTEG) || (state_reg == ST_DERIV),
        "multiplier finished outside a product phase")

    // a new period is only taken with both serial units at rest
    `PMSC_ASSERT_NOW(a_units_idle_on_accept, meas_fire,
        !div_sts.busy && !mul_sts.busy,
        "period transaction accepted while a serial unit is busy")

    // a negative pid sum must give zero drive
    `PMSC_ASSERT_NEXT(a_neg_sum_zero_duty, out_load && sum_reg[SUM_W-1],
        result.valid && (result.drive_duty == '0),
        "negative pid sum did not give zero drive")

endmodule
